// ----- hdl/yti_pkg.sv -----
// Shared types, constants and angle helpers for the yaw table interpolator.
// No dependencies; every other file of the block but yti_ram imports this package.
`default_nettype none

package yti_pkg;

  // Block sizing
  localparam int TABLE_DEPTH     = 256;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int TICK_RATE       = 100;

  // Field widths
  localparam int ANGLE_W    = 16;
  localparam int TIME_W     = 32;
  localparam int INDEX_W    = 8;
  localparam int SPACING_W  = 24;
  localparam int COUNT_W    = 9;
  localparam int STEP_W     = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Table addressing
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  // Register reset values
  localparam logic [SPACING_W-1:0] SPACING_RST = SPACING_W'(655);
  localparam logic [COUNT_W-1:0]   COUNT_RST   = COUNT_W'(1);
  localparam logic [STEP_W-1:0]    STEP_RST    = STEP_W'(257);

  // pi rounded from a Q30 value to the angle format, and 2*pi
  localparam longint PI_Q30 = 64'd3373259369;
  localparam int PI_FX = int'((PI_Q30 + (64'd1 << (29 - ANGLE_FRAC_BITS)))
                              >> (30 - ANGLE_FRAC_BITS));

  // Extended angle arithmetic: holds sums of two angles and 2*pi offsets
  localparam int ANG_X_W = ANGLE_W + 2;
  localparam logic signed [ANG_X_W-1:0] PI_X     = ANG_X_W'(PI_FX);
  localparam logic signed [ANG_X_W-1:0] NEG_PI_X = -ANG_X_W'(PI_FX);
  localparam logic signed [ANG_X_W-1:0] TWO_PI_X = ANG_X_W'(2 * PI_FX);
  localparam logic [STEP_W-1:0]         PI_STEP  = STEP_W'(PI_FX);

  // Interpolation: wrapped difference magnitude never exceeds pi
  localparam int ERR_MAG_W     = $clog2(PI_FX + 1);
  localparam int MAG_W         = ERR_MAG_W + SPACING_W;
  localparam int INTERP_Q_BITS = 16;
  localparam int DIVIDEND_W    = SPACING_W + INTERP_Q_BITS;

  // Divider iteration counter holds the longest run
  localparam int DIV_CNT_W = $clog2(TIME_W + 1);

  // Rate product: angle times tick rate, plus sign
  localparam int RATE_PROD_W = ANGLE_W + $clog2(TICK_RATE + 1) + 1;
  localparam int RATE_MAX    = 32767;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_SPACING = 2'd0,
    CFG_POINT_COUNT    = 2'd1,
    CFG_MAX_STEP       = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV1,
    ST_RD1,
    ST_RD2,
    ST_QSTART,
    ST_DIV2,
    ST_TEMP,
    ST_DIFF,
    ST_LIMIT,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load_wr;
    logic div1_start;
    logic slot_cap;
    logic rd_next;
    logic err_cap;
    logic div2_start;
    logic temp_cap;
    logic diff_cap;
    logic limit_cap;
    logic out_load;
  } yti_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic clamp;
  } yti_stat_t;

  // Fold once by 2*pi when outside [-pi, pi]
  function automatic logic signed [ANG_X_W-1:0] wrap_once(
    input logic signed [ANG_X_W-1:0] a
  );
    logic signed [ANG_X_W-1:0] r;
    if (a > PI_X) begin
      r = a - TWO_PI_X;
    end else if (a < NEG_PI_X) begin
      r = a + TWO_PI_X;
    end else begin
      r = a;
    end
    return r;
  endfunction

  // Fold once, then clamp into [-pi, pi]
  function automatic logic signed [ANG_X_W-1:0] wrap_clamp(
    input logic signed [ANG_X_W-1:0] a
  );
    logic signed [ANG_X_W-1:0] r;
    r = wrap_once(a);
    if (r > PI_X) begin
      r = PI_X;
    end
    if (r < NEG_PI_X) begin
      r = NEG_PI_X;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/yaw_table_interp_slew_limiter_unit.sv -----
// Yaw table interpolator with wrapped slew limit: top level.
// Depends on yti_pkg, yti_ctrl and yti_datapath (which holds yti_div and yti_ram).
//
// The unit keeps a 256-entry table of headings spaced sample_spacing apart in
// time (1/65536 s units) and the last heading it issued. A load transaction
// (opcode 0) writes one table point and produces no result.
// A sample transaction (opcode 1) divides its time by the spacing to get a slot
// and a remainder, clamps the slot to the last valid point, interpolates toward
// the next point along the shorter way around the circle with round-to-nearest,
// wraps into [-pi, pi], limits the change from the last heading to max_step,
// and returns the heading plus a rate of change times 100, saturated to 32767.
// Angles are signed with 13 fraction bits; pi is 25736. The shared divider
// yields one quotient bit per cycle and runs 32 steps for the slot and 16 for
// the rounded offset; a sample whose time lies at or past the last point skips
// the second run. New input is taken only while the unit is idle, but a
// finished result waits in its own output register, so the next transaction
// starts without waiting for the result to be taken. Read table entries only
// after writing them; the table has no reset. Write configuration only while
// the unit is idle.
`default_nettype none

module yaw_table_interp_slew_limiter_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // Configuration write port
  input  wire logic                                  cfg_wr_en,
  input  wire logic        [yti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [yti_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input transactions
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  in_opcode,
  input  wire logic        [yti_pkg::INDEX_W-1:0]    in_point_index,
  input  wire logic signed [yti_pkg::ANGLE_W-1:0]    in_point_angle,
  input  wire logic        [yti_pkg::TIME_W-1:0]     in_sample_time,
  // Result transactions
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed      [yti_pkg::ANGLE_W-1:0]    out_heading,
  output logic signed      [yti_pkg::ANGLE_W-1:0]    out_heading_rate
);

  import yti_pkg::*;

  yti_cmd_t  cmd;
  yti_stat_t stat;

  // Sequence each sample: divide, read table, interpolate, limit, hand off
  yti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold config, table, divider and all arithmetic registers
  yti_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_point_index   (in_point_index),
    .in_point_angle   (in_point_angle),
    .in_sample_time   (in_sample_time),
    .cmd              (cmd),
    .stat             (stat),
    .out_heading      (out_heading),
    .out_heading_rate (out_heading_rate)
  );

endmodule

`default_nettype wire

// ----- hdl/yti_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module yti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hdl/yti_div.sv -----
// Restoring divider, one quotient bit per cycle, with preloadable partial remainder.
// Depends on yti_pkg for widths.
`default_nettype none

module yti_div (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [yti_pkg::DIV_CNT_W-1:0]   iters,
  input  wire logic [yti_pkg::SPACING_W-1:0]   divisor,
  input  wire logic [yti_pkg::SPACING_W-1:0]   rem_init,
  input  wire logic [yti_pkg::TIME_W-1:0]      num_init,
  output logic                                 busy,
  output logic      [yti_pkg::TIME_W-1:0]      quot,
  output logic      [yti_pkg::SPACING_W-1:0]   rem
);

  import yti_pkg::*;

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [SPACING_W-1:0] rem_r;
  logic [SPACING_W-1:0] rem_nxt;
  logic [SPACING_W-1:0] divisor_r;
  logic [TIME_W-1:0]    num_r;
  logic [TIME_W-1:0]    quot_r;
  logic [SPACING_W:0]   trial;
  logic                 fits;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial   = {rem_r, num_r[TIME_W-1]};
    fits    = (trial >= {1'b0, divisor_r});
    rem_nxt = fits ? SPACING_W'(trial - {1'b0, divisor_r}) : trial[SPACING_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= iters;
    end else if (busy_r) begin
      cnt_r <= cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r     <= rem_init;
      num_r     <= num_init;
      quot_r    <= '0;
      divisor_r <= divisor;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      num_r  <= {num_r[TIME_W-2:0], 1'b0};
      quot_r <= {quot_r[TIME_W-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;
  assign rem  = rem_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < divisor_r))
    else $error("partial remainder reached the divisor");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && cnt_r == DIV_CNT_W'(1)) |=> !busy_r)
    else $error("divider ran past its iteration count");

endmodule

`default_nettype wire

// ----- hdl/yti_datapath.sv -----
// Datapath: config registers, heading table, divider, interpolation, slew limit.
// Depends on yti_pkg, yti_ram and yti_div; driven by commands from yti_ctrl.
`default_nettype none

module yti_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_wr_en,
  input  wire logic        [yti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [yti_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic        [yti_pkg::INDEX_W-1:0]   in_point_index,
  input  wire logic signed [yti_pkg::ANGLE_W-1:0]   in_point_angle,
  input  wire logic        [yti_pkg::TIME_W-1:0]    in_sample_time,
  input  wire yti_pkg::yti_cmd_t                    cmd,
  output yti_pkg::yti_stat_t                        stat,
  output logic signed      [yti_pkg::ANGLE_W-1:0]   out_heading,
  output logic signed      [yti_pkg::ANGLE_W-1:0]   out_heading_rate
);

  import yti_pkg::*;

  // Configuration
  logic [SPACING_W-1:0] sample_spacing_r;
  logic [COUNT_W-1:0]   point_count_r;
  logic [STEP_W-1:0]    max_step_r;
  logic [SPACING_W-1:0] spacing_eff;
  logic [CNT_W-1:0]     count_eff;
  logic [ADDR_W-1:0]    last_idx;
  logic [STEP_W-1:0]    step_eff;

  // Divider
  logic                 div_start;
  logic [DIV_CNT_W-1:0] div_iters;
  logic [SPACING_W-1:0] div_rem_init;
  logic [TIME_W-1:0]    div_num_init;
  logic                 div_busy;
  logic [TIME_W-1:0]    div_quot;
  logic [SPACING_W-1:0] div_rem;

  // Table
  logic                 ram_we;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [ANGLE_W-1:0]   ram_rdata;

  // Sample pipeline registers
  logic                        clamp_r;
  logic                        clamp_nxt;
  logic [ADDR_W-1:0]           slot_r;
  logic [SPACING_W-1:0]        rem_r;
  logic signed [ANGLE_W-1:0]   base_r;
  logic                        err_neg_r;
  logic [DIVIDEND_W-1:0]       num2_r;
  logic [DIVIDEND_W-1:0]       num2_nxt;
  logic signed [ANGLE_W-1:0]   temp_r;
  logic signed [ANGLE_W-1:0]   temp_nxt;
  logic signed [ANGLE_W-1:0]   d_r;
  logic signed [ANGLE_W-1:0]   d_nxt;
  logic signed [ANGLE_W-1:0]   head_r;
  logic signed [ANGLE_W-1:0]   head_nxt;
  logic signed [ANGLE_W-1:0]   dlim_r;
  logic signed [ANGLE_W-1:0]   dlim_nxt;
  logic signed [ANGLE_W-1:0]   last_heading_r;
  logic signed [ANGLE_W-1:0]   out_heading_r;
  logic signed [ANGLE_W-1:0]   out_rate_r;
  logic signed [ANGLE_W-1:0]   rate_nxt;

  // Intermediate arithmetic
  logic signed [ANG_X_W-1:0]     base_x;
  logic signed [ANG_X_W-1:0]     next_x;
  logic signed [ANG_X_W-1:0]     err_x;
  logic signed [ANG_X_W-1:0]     err_abs;
  logic [ERR_MAG_W-1:0]          err_mag;
  logic [MAG_W-1:0]              mag;
  logic signed [ANG_X_W-1:0]     q_x;
  logic signed [ANG_X_W-1:0]     interp_x;
  logic signed [ANG_X_W-1:0]     d_x;
  logic signed [ANG_X_W-1:0]     last_x;
  logic signed [ANG_X_W-1:0]     step_x;
  logic signed [RATE_PROD_W-1:0] rate_prod;

  localparam logic signed [RATE_PROD_W-1:0] TICK_X    = RATE_PROD_W'(TICK_RATE);
  localparam logic signed [RATE_PROD_W-1:0] RATE_HI_X = RATE_PROD_W'(RATE_MAX);
  localparam logic signed [RATE_PROD_W-1:0] RATE_LO_X = -RATE_PROD_W'(RATE_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_spacing_r <= SPACING_RST;
      point_count_r    <= COUNT_RST;
      max_step_r       <= STEP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SAMPLE_SPACING: sample_spacing_r <= SPACING_W'(cfg_wdata);
        CFG_POINT_COUNT:    point_count_r    <= COUNT_W'(cfg_wdata);
        CFG_MAX_STEP:       max_step_r       <= STEP_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    spacing_eff = (sample_spacing_r == '0) ? SPACING_W'(1) : sample_spacing_r;
    if (point_count_r == '0) begin
      count_eff = CNT_W'(1);
    end else if (int'(point_count_r) > TABLE_DEPTH) begin
      count_eff = CNT_W'(TABLE_DEPTH);
    end else begin
      count_eff = CNT_W'(point_count_r);
    end
    last_idx = ADDR_W'(count_eff - CNT_W'(1));
    step_eff = (max_step_r > PI_STEP) ? PI_STEP : max_step_r;
  end

  // Divider runs: slot from the time, then the rounded interpolation offset
  always_comb begin
    div_start = cmd.div1_start | cmd.div2_start;
    if (cmd.div2_start) begin
      div_iters    = DIV_CNT_W'(INTERP_Q_BITS);
      div_rem_init = num2_r[DIVIDEND_W-1 -: SPACING_W];
      div_num_init = {num2_r[INTERP_Q_BITS-1:0], {(TIME_W - INTERP_Q_BITS){1'b0}}};
    end else begin
      div_iters    = DIV_CNT_W'(TIME_W);
      div_rem_init = '0;
      div_num_init = in_sample_time;
    end
  end

  yti_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .iters    (div_iters),
    .divisor  (spacing_eff),
    .rem_init (div_rem_init),
    .num_init (div_num_init),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    clamp_nxt = (div_quot >= TIME_W'(last_idx));
    ram_we    = cmd.load_wr && (int'(in_point_index) < TABLE_DEPTH);
    ram_re    = cmd.slot_cap | cmd.rd_next;
    if (cmd.slot_cap) begin
      ram_raddr = clamp_nxt ? last_idx : div_quot[ADDR_W-1:0];
    end else begin
      ram_raddr = slot_r + ADDR_W'(1);
    end
  end

  yti_ram #(
    .WIDTH (ANGLE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_point_index)),
    .wdata (in_point_angle),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    base_x   = ANG_X_W'(base_r);
    next_x   = ANG_X_W'($signed(ram_rdata));
    err_x    = wrap_once(next_x - base_x);
    err_abs  = err_x[ANG_X_W-1] ? -err_x : err_x;
    err_mag  = ERR_MAG_W'(err_abs);
    mag      = MAG_W'(err_mag) * MAG_W'(rem_r);
    num2_nxt = DIVIDEND_W'(mag) + DIVIDEND_W'(spacing_eff >> 1);

    q_x = $signed(ANG_X_W'(div_quot[INTERP_Q_BITS-1:0]));
    if (clamp_r) begin
      interp_x = base_x;
    end else if (err_neg_r) begin
      interp_x = base_x - q_x;
    end else begin
      interp_x = base_x + q_x;
    end
    temp_nxt = ANGLE_W'(wrap_clamp(interp_x));

    last_x = ANG_X_W'(last_heading_r);
    d_nxt  = ANGLE_W'(wrap_once(ANG_X_W'(temp_r) - last_x));

    // Limit the per-tick change
    d_x    = ANG_X_W'(d_r);
    step_x = $signed(ANG_X_W'(step_eff));
    if (d_x < -step_x) begin
      dlim_nxt = ANGLE_W'(-step_x);
      head_nxt = ANGLE_W'(wrap_clamp(last_x - step_x));
    end else if (d_x > step_x) begin
      dlim_nxt = ANGLE_W'(step_x);
      head_nxt = ANGLE_W'(wrap_clamp(last_x + step_x));
    end else begin
      dlim_nxt = d_r;
      head_nxt = temp_r;
    end

    rate_prod = RATE_PROD_W'(dlim_r) * TICK_X;
    if (rate_prod > RATE_HI_X) begin
      rate_nxt = ANGLE_W'(RATE_HI_X);
    end else if (rate_prod < RATE_LO_X) begin
      rate_nxt = ANGLE_W'(RATE_LO_X);
    end else begin
      rate_nxt = ANGLE_W'(rate_prod);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_heading_r <= '0;
    end else if (cmd.out_load) begin
      last_heading_r <= head_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.slot_cap) begin
      clamp_r <= clamp_nxt;
      slot_r  <= div_quot[ADDR_W-1:0];
      rem_r   <= div_rem;
    end
    if (cmd.rd_next) begin
      base_r <= $signed(ram_rdata);
    end
    if (cmd.err_cap) begin
      err_neg_r <= err_x[ANG_X_W-1];
      num2_r    <= num2_nxt;
    end
    if (cmd.temp_cap) begin
      temp_r <= temp_nxt;
    end
    if (cmd.diff_cap) begin
      d_r <= d_nxt;
    end
    if (cmd.limit_cap) begin
      head_r <= head_nxt;
      dlim_r <= dlim_nxt;
    end
    if (cmd.out_load) begin
      out_heading_r <= head_r;
      out_rate_r    <= rate_nxt;
    end
  end

  assign stat.div_busy     = div_busy;
  assign stat.clamp        = clamp_r;
  assign out_heading       = out_heading_r;
  assign out_heading_rate  = out_rate_r;

endmodule

`default_nettype wire

// ----- hdl/yti_ctrl.sv -----
// Controller state machine: writes table loads and sequences one sample through the datapath.
// Depends on yti_pkg; drives yti_datapath through the command struct.
`default_nettype none

module yti_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_opcode,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire yti_pkg::yti_stat_t stat,
  output yti_pkg::yti_cmd_t       cmd
);

  import yti_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_free  = !out_valid_r || out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == OP_SAMPLE) begin
            cmd.div1_start = 1'b1;
            state_nxt      = ST_DIV1;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ST_DIV1: begin
        if (!stat.div_busy) begin
          cmd.slot_cap = 1'b1;
          state_nxt    = ST_RD1;
        end
      end
      ST_RD1: begin
        cmd.rd_next = 1'b1;
        state_nxt   = stat.clamp ? ST_TEMP : ST_RD2;
      end
      ST_RD2: begin
        cmd.err_cap = 1'b1;
        state_nxt   = ST_QSTART;
      end
      ST_QSTART: begin
        cmd.div2_start = 1'b1;
        state_nxt      = ST_DIV2;
      end
      ST_DIV2: begin
        if (!stat.div_busy) begin
          state_nxt = ST_TEMP;
        end
      end
      ST_TEMP: begin
        cmd.temp_cap = 1'b1;
        state_nxt    = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff_cap = 1'b1;
        state_nxt    = ST_LIMIT;
      end
      ST_LIMIT: begin
        cmd.limit_cap = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while still pending");

  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && in_opcode == OP_SAMPLE) |=> (state_r == ST_DIV1))
    else $error("accepted sample did not start the divider");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("result raised outside the output state");

endmodule

`default_nettype wire
